### hdl/icgm_pkg.sv
// Shared types, codes and reset values for the input change glitch monitor.
`timescale 1ns / 1ps

package icgm_pkg;

   localparam int DEFAULT_INPUT_WIDTH = 16;
   localparam int LEVEL_W             = 16;
   localparam int TIME_W              = 32;
   localparam int COUNT_W             = 8;
   localparam int RATE_W              = 16;
   localparam int KIND_W              = 2;
   localparam int CSR_IDX_W           = 3;
   localparam int CSR_DATA_W          = 32;

   // Result queue: depth must be a power of two and at least four.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [KIND_W-1:0] KIND_CHANGE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GLITCH   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FILTERED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SUMMARY  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WATCH_MASK    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLITCH_WINDOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_TIME   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EVENTS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_WINDOW   = 3'd4;

   localparam logic [LEVEL_W-1:0] RESET_WATCH_MASK    = 16'd2047;
   localparam logic [TIME_W-1:0]  RESET_GLITCH_WINDOW = 32'd5000;
   localparam logic [TIME_W-1:0]  RESET_FILTER_TIME   = 32'd3000;
   localparam logic [COUNT_W-1:0] RESET_MAX_EVENTS    = 8'd10;
   localparam logic [RATE_W-1:0]  RESET_RATE_WINDOW   = 16'd1000;

   typedef struct packed {
      logic [LEVEL_W-1:0] watch_mask;
      logic [TIME_W-1:0]  glitch_window_us;
      logic [TIME_W-1:0]  filter_time_us;
      logic [COUNT_W-1:0] max_events_per_window;
      logic [RATE_W-1:0]  rate_window_ms;
   } icgm_cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] raw_inputs;
      logic [TIME_W-1:0]  time_us;
      logic [TIME_W-1:0]  time_ms;
   } icgm_item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  event_kind;
      logic [LEVEL_W-1:0] changed_bits;
      logic [LEVEL_W-1:0] new_levels;
      logic [TIME_W-1:0]  duration_us;
      logic [TIME_W-1:0]  suppressed_count;
      logic [TIME_W-1:0]  glitch_total;
      logic               last_of_run;
   } icgm_result_type;

endpackage

### hdl/input_change_glitch_monitor_top.sv
// Top level of the input change glitch monitor: sample register, config, core and queue.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  raw_inputs, time_us, time_ms
//   rsp      out        rsp_valid/rsp_stall  event_kind .. last_of_run
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A sample taken at an edge sits in the sample register, where the core judges it; once
// the queue has room for two words, its words are written into the four-word queue and
// are offered at rsp from then on.
// One sample per cycle is taken while req_stall is low; a sample that gives a summary and
// an event puts two words in the queue, which drains one word a cycle while rsp_stall is low.
// req_stall rises only when the queue lacks room for two words and a sample is held.
// Reset is synchronous; it clears the control state and restores the register defaults.
`timescale 1ns / 1ps

module input_change_glitch_monitor_top
   import icgm_pkg::*;
#(
   parameter int INPUT_WIDTH = DEFAULT_INPUT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [INPUT_WIDTH-1:0] req_raw_inputs,
   input  logic [TIME_W-1:0]      req_time_us,
   input  logic [TIME_W-1:0]      req_time_ms,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KIND_W-1:0]      rsp_event_kind,
   output logic [LEVEL_W-1:0]     rsp_changed_bits,
   output logic [LEVEL_W-1:0]     rsp_new_levels,
   output logic [TIME_W-1:0]      rsp_duration_us,
   output logic [TIME_W-1:0]      rsp_suppressed_count,
   output logic [TIME_W-1:0]      rsp_glitch_total,
   output logic                   rsp_last_of_run,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LVL_W = (INPUT_WIDTH < LEVEL_W) ? INPUT_WIDTH : LEVEL_W;

   icgm_cfg_type    cfg_ff, cfg_in;
   logic            held_ff, held_in;
   icgm_item_type   item_ff;
   icgm_item_type   item_in;
   logic            accept;
   logic            go;
   logic            has_room;
   logic [1:0]      res_count;
   icgm_result_type res0;
   icgm_result_type res1;
   icgm_result_type out_word;

   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WATCH_MASK:    cfg_in.watch_mask            = csr_wdata[LEVEL_W-1:0];
            CSR_GLITCH_WINDOW: cfg_in.glitch_window_us      = csr_wdata[TIME_W-1:0];
            CSR_FILTER_TIME:   cfg_in.filter_time_us        = csr_wdata[TIME_W-1:0];
            CSR_MAX_EVENTS:    cfg_in.max_events_per_window = csr_wdata[COUNT_W-1:0];
            CSR_RATE_WINDOW:   cfg_in.rate_window_ms        = csr_wdata[RATE_W-1:0];
            default:           cfg_in                       = cfg_ff;
         endcase
      end
   end

   always_comb begin
      item_in.raw_inputs             = '0;
      item_in.raw_inputs[LVL_W-1:0]  = req_raw_inputs[LVL_W-1:0];
      item_in.time_us                = req_time_us;
      item_in.time_ms                = req_time_ms;

      go        = held_ff && has_room;
      req_stall = held_ff && !has_room;
      accept    = req_valid && !req_stall;
      held_in   = accept ? 1'b1 : (go ? 1'b0 : held_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.watch_mask            <= RESET_WATCH_MASK;
         cfg_ff.glitch_window_us      <= RESET_GLITCH_WINDOW;
         cfg_ff.filter_time_us        <= RESET_FILTER_TIME;
         cfg_ff.max_events_per_window <= RESET_MAX_EVENTS;
         cfg_ff.rate_window_ms        <= RESET_RATE_WINDOW;
         held_ff                      <= 1'b0;
      end else begin
         cfg_ff  <= cfg_in;
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   icgm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .go        (go),
      .item      (item_ff),
      .res_count (res_count),
      .res0      (res0),
      .res1      (res1)
   );

   icgm_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_count),
      .push0      (res0),
      .push1      (res1),
      .has_room   (has_room),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_word   (out_word)
   );

   assign rsp_event_kind       = out_word.event_kind;
   assign rsp_changed_bits     = out_word.changed_bits;
   assign rsp_new_levels       = out_word.new_levels;
   assign rsp_duration_us      = out_word.duration_us;
   assign rsp_suppressed_count = out_word.suppressed_count;
   assign rsp_glitch_total     = out_word.glitch_total;
   assign rsp_last_of_run      = out_word.last_of_run;

endmodule

### hdl/icgm_core.sv
// Change detection, glitch classification and rate limiting for one held sample.
`timescale 1ns / 1ps

module icgm_core
   import icgm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  icgm_cfg_type    cfg,
   input  logic            go,
   input  icgm_item_type   item,
   output logic [1:0]      res_count,
   output icgm_result_type res0,
   output icgm_result_type res1
);

   logic               started_ff, started_in;
   logic [LEVEL_W-1:0] prev_levels_ff, prev_levels_in;
   logic [LEVEL_W-1:0] prev_changed_ff, prev_changed_in;
   logic [TIME_W-1:0]  prev_time_ff, prev_time_in;
   logic [TIME_W-1:0]  win_start_ff, win_start_in;
   logic [COUNT_W-1:0] win_count_ff, win_count_in;
   logic [TIME_W-1:0]  suppressed_ff, suppressed_in;
   logic [TIME_W-1:0]  glitches_ff, glitches_in;

   logic [LEVEL_W-1:0] levels;
   logic [LEVEL_W-1:0] changed;
   logic [TIME_W-1:0]  dt;
   logic [TIME_W-1:0]  win_age;
   logic               active;
   logic               glitch;
   logic               new_window;
   logic               summary;
   logic               report;
   logic [COUNT_W-1:0] count_eff;
   logic [TIME_W-1:0]  supp_eff;
   logic [KIND_W-1:0]  kind;
   icgm_result_type    sum_res;
   icgm_result_type    evt_res;

   always_comb begin
      levels     = item.raw_inputs & cfg.watch_mask;
      changed    = levels ^ prev_levels_ff;
      dt         = item.time_us - prev_time_ff;
      win_age    = item.time_ms - win_start_ff;
      active     = started_ff && (levels != prev_levels_ff);
      glitch     = (changed == prev_changed_ff) && (dt < cfg.glitch_window_us);
      new_window = win_age >= {{(TIME_W-RATE_W){1'b0}}, cfg.rate_window_ms};
      summary    = active && new_window && (suppressed_ff != '0);
      count_eff  = new_window ? '0 : win_count_ff;
      supp_eff   = new_window ? '0 : suppressed_ff;
      report     = active && (count_eff < cfg.max_events_per_window);

      if (!glitch) begin
         kind = KIND_CHANGE;
      end else if (dt < cfg.filter_time_us) begin
         kind = KIND_FILTERED;
      end else begin
         kind = KIND_GLITCH;
      end

      glitches_in = glitches_ff;
      if (go && active && glitch) begin
         glitches_in = glitches_ff + 1'b1;
      end

      sum_res.event_kind       = KIND_SUMMARY;
      sum_res.changed_bits     = '0;
      sum_res.new_levels       = '0;
      sum_res.duration_us      = '0;
      sum_res.suppressed_count = suppressed_ff;
      sum_res.glitch_total     = glitches_in;
      sum_res.last_of_run      = !report;

      evt_res.event_kind       = kind;
      evt_res.changed_bits     = changed;
      evt_res.new_levels       = levels;
      evt_res.duration_us      = dt;
      evt_res.suppressed_count = '0;
      evt_res.glitch_total     = glitches_in;
      evt_res.last_of_run      = 1'b1;

      res0      = summary ? sum_res : evt_res;
      res1      = evt_res;
      res_count = go ? ({1'b0, summary} + {1'b0, report}) : 2'd0;

      started_in      = started_ff;
      prev_levels_in  = prev_levels_ff;
      prev_changed_in = prev_changed_ff;
      prev_time_in    = prev_time_ff;
      win_start_in    = win_start_ff;
      win_count_in    = win_count_ff;
      suppressed_in   = suppressed_ff;

      if (go && !started_ff) begin
         // The first sample only sets the reference levels.
         started_in     = 1'b1;
         prev_levels_in = levels;
      end else if (go && active) begin
         prev_levels_in  = levels;
         prev_changed_in = changed;
         prev_time_in    = item.time_us;
         if (new_window) begin
            win_start_in = item.time_ms;
         end
         if (report) begin
            win_count_in  = count_eff + 1'b1;
            suppressed_in = supp_eff;
         end else begin
            win_count_in  = count_eff;
            suppressed_in = (supp_eff == '1) ? supp_eff : supp_eff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff      <= 1'b0;
         prev_levels_ff  <= '0;
         prev_changed_ff <= '0;
         prev_time_ff    <= '0;
         win_start_ff    <= '0;
         win_count_ff    <= '0;
         suppressed_ff   <= '0;
         glitches_ff     <= '0;
      end else begin
         started_ff      <= started_in;
         prev_levels_ff  <= prev_levels_in;
         prev_changed_ff <= prev_changed_in;
         prev_time_ff    <= prev_time_in;
         win_start_ff    <= win_start_in;
         win_count_ff    <= win_count_in;
         suppressed_ff   <= suppressed_in;
         glitches_ff     <= glitches_in;
      end
   end

endmodule

### hdl/icgm_fifo.sv
// Small result queue that takes up to two words per cycle and gives one while out_stall is low.
`timescale 1ns / 1ps

module icgm_fifo
   import icgm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [1:0]      push_count,
   input  icgm_result_type push0,
   input  icgm_result_type push1,
   output logic            has_room,
   output logic            out_valid,
   input  logic            out_stall,
   output icgm_result_type out_word
);

   icgm_result_type        mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic [FIFO_PTR_W-1:0]  wr_next;
   logic                   pop;

   always_comb begin
      wr_next   = wr_ptr_ff + 1'b1;
      out_valid = count_ff != '0;
      out_word  = mem_ff[rd_ptr_ff];
      pop       = out_valid && !out_stall;
      // Room for two words is judged before this cycle's pop.
      has_room  = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hdl/icgm_checker.sv
// Port-level checks on the monitor's result channel, bound to the top level.
`timescale 1ns / 1ps

module icgm_checker
   import icgm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [KIND_W-1:0]  rsp_event_kind,
   input logic [LEVEL_W-1:0] rsp_changed_bits,
   input logic [LEVEL_W-1:0] rsp_new_levels,
   input logic [TIME_W-1:0]  rsp_duration_us,
   input logic [TIME_W-1:0]  rsp_suppressed_count,
   input logic [TIME_W-1:0]  rsp_glitch_total,
   input logic               rsp_last_of_run
);

   // A stalled word stays offered with its kind, duration, glitch total and last flag unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_duration_us) && $stable(rsp_glitch_total)
         && $stable(rsp_last_of_run))
      else $error("stalled result word changed");

   // No result can be pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A summary carries only the suppressed count, the glitch total and the last flag; its suppressed count is nonzero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_SUMMARY |->
         rsp_changed_bits == '0 && rsp_new_levels == '0 && rsp_duration_us == '0
         && rsp_suppressed_count != '0)
      else $error("summary word carries event fields");

   // An event word always ends its sample's run and carries no suppressed count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != KIND_SUMMARY |->
         rsp_last_of_run && rsp_suppressed_count == '0 && rsp_changed_bits != '0)
      else $error("event word malformed");

endmodule

bind input_change_glitch_monitor_top icgm_checker u_icgm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_event_kind       (rsp_event_kind),
   .rsp_changed_bits     (rsp_changed_bits),
   .rsp_new_levels       (rsp_new_levels),
   .rsp_duration_us      (rsp_duration_us),
   .rsp_suppressed_count (rsp_suppressed_count),
   .rsp_glitch_total     (rsp_glitch_total),
   .rsp_last_of_run      (rsp_last_of_run)
);
